// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the timeout request checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/btrc_pkg.sv -----
// Types and constants of the timeout request checker.
`default_nettype none

package btrc_pkg;

   localparam int ValueWidth      = 27;
   localparam int WordWidth       = 32;
   localparam int LengthWidth     = 8;
   localparam int NibbleWidth     = 4;
   localparam int NibblesPerStage = 2;
   localparam int StageCount      = 4;

   localparam logic [LengthWidth-1:0] ReqLength = 8'd5;
   localparam logic [NibbleWidth-1:0] DigitMax  = 4'd9;

   localparam logic StatusOk      = 1'b0;
   localparam logic StatusIllegal = 1'b1;

   // Payload carried from one digit stage to the next.
   typedef struct packed {
      logic                   valid;
      logic                   len_ok;
      logic [ValueWidth-1:0]  acc;
      logic [WordWidth-1:0]   echo;
      logic [WordWidth-1:0]   rest;
   } btrc_stage_type;

   // Append one decimal digit to a binary accumulator: acc * 10 + digit.
   function automatic logic [ValueWidth-1:0] mul10_add(
      input logic [ValueWidth-1:0]  acc,
      input logic [NibbleWidth-1:0] digit
   );
      logic [ValueWidth+2:0] wide;
      wide = {acc, 3'b000} + {2'b00, acc, 1'b0}
           + {{(ValueWidth-1){1'b0}}, digit};
      return wide[ValueWidth-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/bcd_timeout_request_check_core.sv -----
// Top level of the timeout request checker: digit pipeline and result register.
`default_nettype none
`include "assert_macros.svh"

// Usage
//   Request channel: drive req_pdu_length and req_bcd_word and raise start;
//   the request is taken at a rising edge where start is high and busy is low.
//   busy is high only while reset is asserted, so a request may be issued in
//   every cycle.
//   Result channel: rsp_valid is high for exactly one cycle per request, with
//   rsp_status, rsp_timeout_value and rsp_echo_bcd valid in that cycle.
//   Pipeline: a request passes the four digit stages, which each fold two
//   nibbles (multiply by ten, add), and then one result stage, which applies
//   the length and zero checks and registers the result outputs.
//   Throughput: one request per cycle, fully pipelined, results in order.
//   Reset: synchronous; clears every valid bit, so requests in flight are
//   dropped and no result is produced for them.
//   Stall: the receiver cannot hold results off; there is no back pressure.
module bcd_timeout_request_check_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic [btrc_pkg::LengthWidth-1:0]    req_pdu_length,
   input  wire logic [btrc_pkg::WordWidth-1:0]      req_bcd_word,
   output      logic                                rsp_valid,
   output      logic                                rsp_status,
   output      logic [btrc_pkg::ValueWidth-1:0]     rsp_timeout_value,
   output      logic [btrc_pkg::WordWidth-1:0]      rsp_echo_bcd
);

   // Stage bus: entry 0 is the incoming request, entry k leaves stage k.
   btrc_pkg::btrc_stage_type stage_bus [0:btrc_pkg::StageCount];

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_status_ff, rsp_status_in;
   logic [btrc_pkg::ValueWidth-1:0]   rsp_timeout_value_ff, rsp_timeout_value_in;
   logic [btrc_pkg::WordWidth-1:0]    rsp_echo_bcd_ff, rsp_echo_bcd_in;

   // Hold off requests only while reset is applied.
   assign busy = reset;

   // Load a new request into the head of the pipeline.
   always_comb begin
      stage_bus[0].valid  = start && !busy;
      stage_bus[0].len_ok = (req_pdu_length == btrc_pkg::ReqLength);
      stage_bus[0].acc    = '0;
      stage_bus[0].echo   = '0;
      stage_bus[0].rest   = req_bcd_word;
   end

   // Advance two nibbles per stage, most significant nibble first.
   for (genvar s = 0; s < btrc_pkg::StageCount; s++) begin : g_stage
      btrc_digit_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage_bus[s]),
         .stage_out (stage_bus[s+1])
      );
   end

   // Result stage: reject a bad length or a zero value, and zero the payload.
   // The echo word is the kept digits closed up and right aligned, which is
   // exactly the value re-encoded as eight BCD digits.
   always_comb begin
      rsp_valid_in = stage_bus[btrc_pkg::StageCount].valid;
      if (stage_bus[btrc_pkg::StageCount].len_ok
          && (stage_bus[btrc_pkg::StageCount].acc != '0)) begin
         rsp_status_in        = btrc_pkg::StatusOk;
         rsp_timeout_value_in = stage_bus[btrc_pkg::StageCount].acc;
         rsp_echo_bcd_in      = stage_bus[btrc_pkg::StageCount].echo;
      end else begin
         rsp_status_in        = btrc_pkg::StatusIllegal;
         rsp_timeout_value_in = '0;
         rsp_echo_bcd_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff        <= rsp_status_in;
      rsp_timeout_value_ff <= rsp_timeout_value_in;
      rsp_echo_bcd_ff      <= rsp_echo_bcd_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_timeout_value = rsp_timeout_value_ff;
   assign rsp_echo_bcd      = rsp_echo_bcd_ff;

   // Every accepted request yields its result.
   `ASSERT_IMPLY(a_latency, clock, reset, start && !busy, ##5 rsp_valid, "result missing")

   // No result appears without an earlier accepted request.
   `ASSERT_IMPLY(a_no_spurious, clock, reset,
      rsp_valid, $past(start && !busy, 5), "spurious result")

   // An accepted result carries a nonzero value.
   `ASSERT_IMPLY(a_ok_nonzero, clock, reset,
      rsp_valid && (rsp_status == btrc_pkg::StatusOk), rsp_timeout_value != '0,
      "accepted zero value")

   // A rejected result carries zero payload.
   `ASSERT_IMPLY(a_reject_zero, clock, reset,
      rsp_valid && (rsp_status == btrc_pkg::StatusIllegal),
      (rsp_timeout_value == '0) && (rsp_echo_bcd == '0), "rejected payload not zero")

endmodule

`default_nettype wire

// ----- src/btrc_digit_stage.sv -----
// One pipeline stage of the checker: folds two BCD nibbles into the value.
`default_nettype none

module btrc_digit_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire btrc_pkg::btrc_stage_type  stage_in,
   output      btrc_pkg::btrc_stage_type  stage_out
);

   btrc_pkg::btrc_stage_type stage_ff;
   btrc_pkg::btrc_stage_type stage_in_d;

   logic [btrc_pkg::NibbleWidth-1:0] nib;

   // Skip non-decimal nibbles; kept digits close up in both forms.
   always_comb begin
      stage_in_d = stage_in;
      nib        = '0;
      for (int k = 0; k < btrc_pkg::NibblesPerStage; k++) begin
         nib = stage_in_d.rest[btrc_pkg::WordWidth-1 -: btrc_pkg::NibbleWidth];
         if (nib <= btrc_pkg::DigitMax) begin
            stage_in_d.acc  = btrc_pkg::mul10_add(stage_in_d.acc, nib);
            stage_in_d.echo = {stage_in_d.echo[btrc_pkg::WordWidth-btrc_pkg::NibbleWidth-1:0],
                               nib};
         end
         stage_in_d.rest = {stage_in_d.rest[btrc_pkg::WordWidth-btrc_pkg::NibbleWidth-1:0],
                            {btrc_pkg::NibbleWidth{1'b0}}};
      end
   end

   // Clear only the valid bit on reset; the payload just follows.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in_d.valid;
      end
      stage_ff.len_ok <= stage_in_d.len_ok;
      stage_ff.acc    <= stage_in_d.acc;
      stage_ff.echo   <= stage_in_d.echo;
      stage_ff.rest   <= stage_in_d.rest;
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the BCD timeout request checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ClockHigh   = 10;
   localparam int ClockLow    = 10;
   localparam int ResetCycles = 8;
   // Wait after the last reply before closing the run, so stray replies can show.
   localparam int DrainCycles = 12;
   // Worst case: 960 requests, some with long sender gaps; many times over.
   localparam int CycleLimit  = 400000;
   localparam int PhaseItems  = 235;

   // One reply as the checker should produce it.
   typedef struct {
      logic                            status;
      logic [btrc_pkg::ValueWidth-1:0] value;
      logic [btrc_pkg::WordWidth-1:0]  echo;
   } timeout_reply_type;

   // Predict the reply of each accepted request and check replies in order.
   class timeout_check_board;
      timeout_reply_type pending_replies[$];
      int unsigned       fails;

      function new();
         fails = 0;
      endfunction

      // Decode the request the way the block should and queue the reply.
      function void note_request(logic [btrc_pkg::LengthWidth-1:0] pdu_length,
                                 logic [btrc_pkg::WordWidth-1:0] bcd_word);
         timeout_reply_type                 want;
         int unsigned                       acc;
         int unsigned                       rest;
         logic [btrc_pkg::NibbleWidth-1:0]  nib;
         want.status = btrc_pkg::StatusIllegal;
         want.value  = '0;
         want.echo   = '0;
         acc = 0;
         // Walk from the top nibble down; drop any non-decimal nibble.
         for (int k = 7; k >= 0; k--) begin
            nib = bcd_word[4*k +: 4];
            if (nib <= btrc_pkg::DigitMax) begin
               acc = acc * 10 + nib;
            end
         end
         // Eight digits at most, so only the length and zero checks can fail.
         if (pdu_length == btrc_pkg::ReqLength && acc != 0) begin
            want.status = btrc_pkg::StatusOk;
            want.value  = acc[btrc_pkg::ValueWidth-1:0];
            rest = acc;
            for (int k = 0; k < 8; k++) begin
               want.echo[4*k +: 4] = 4'(rest % 10);
               rest = rest / 10;
            end
         end
         pending_replies.push_back(want);
      endfunction

      // Compare one reply against the oldest prediction.
      function void check_result(logic status, logic [btrc_pkg::ValueWidth-1:0] value,
                                 logic [btrc_pkg::WordWidth-1:0] echo);
         timeout_reply_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: reply with no request pending: status %0b value %0d echo %h",
                     $time, status, value, echo);
            fails++;
            return;
         end
         want = pending_replies.pop_front();
         if (status !== want.status) begin
            $display("%0t: status expected %0b actual %0b", $time, want.status, status);
            fails++;
         end
         if (value !== want.value) begin
            $display("%0t: timeout_value expected %0d actual %0d", $time, want.value, value);
            fails++;
         end
         if (echo !== want.echo) begin
            $display("%0t: echo_bcd expected %h actual %h", $time, want.echo, echo);
            fails++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic [btrc_pkg::LengthWidth-1:0] req_pdu_length = '0;
   logic [btrc_pkg::WordWidth-1:0]   req_bcd_word = '0;
   logic                             busy;
   logic                             rsp_valid;
   logic                             rsp_status;
   logic [btrc_pkg::ValueWidth-1:0]  rsp_timeout_value;
   logic [btrc_pkg::WordWidth-1:0]   rsp_echo_bcd;
   int unsigned                      cycle_count = 0;

   timeout_check_board board = new();

   bcd_timeout_request_check_core DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_pdu_length    (req_pdu_length),
      .req_bcd_word      (req_bcd_word),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_timeout_value (rsp_timeout_value),
      .rsp_echo_bcd      (rsp_echo_bcd)
   );

   always begin
      #ClockLow clock = 1'b1;
      #ClockHigh clock = 1'b0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Sample both channels at the edge; values seen here are the pre-edge ones,
   // so a request counts exactly when the block took it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            board.check_result(rsp_status, rsp_timeout_value, rsp_echo_bcd);
         end
         if (start && !busy) begin
            board.note_request(req_pdu_length, req_bcd_word);
         end
      end
   end

   // Hold start low for a random gap, then present the request and hold it
   // until the block takes it. Returns right after the accepting edge.
   task automatic issue_request(logic [btrc_pkg::LengthWidth-1:0] pdu_length,
                                logic [btrc_pkg::WordWidth-1:0] bcd_word, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start          <= 1'b0;
         req_pdu_length <= btrc_pkg::LengthWidth'($urandom);
         req_bcd_word   <= $urandom;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_pdu_length <= pdu_length;
      req_bcd_word   <= bcd_word;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Mostly well-formed digit strings, some with non-decimal nibbles mixed in,
   // a few zero or all-skipped words, and the rest raw noise.
   function automatic logic [btrc_pkg::WordWidth-1:0] random_bcd_word();
      logic [btrc_pkg::WordWidth-1:0] word;
      int                             mode;
      int                             digits;
      mode   = $urandom_range(99);
      digits = $urandom_range(8, 1);
      word   = '0;
      for (int k = 0; k < 8; k++) begin
         if (k < digits) begin
            word[4*k +: 4] = 4'($urandom_range(9));
         end
      end
      if (mode >= 55 && mode < 80) begin
         // Sprinkle non-decimal nibbles so the remaining digits close up.
         for (int k = 0; k < 8; k++) begin
            if ($urandom_range(99) < 25) begin
               word[4*k +: 4] = 4'($urandom_range(15, 10));
            end
         end
      end else if (mode >= 80 && mode < 88) begin
         // Decodes to zero: only zero digits and skipped nibbles.
         for (int k = 0; k < 8; k++) begin
            word[4*k +: 4] = ($urandom_range(1) == 0) ? 4'h0 : 4'($urandom_range(15, 10));
         end
      end else if (mode >= 88) begin
         word = $urandom;
      end
      return word;
   endfunction

   function automatic logic [btrc_pkg::LengthWidth-1:0] random_pdu_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
         return btrc_pkg::ReqLength;
      end else if (pick < 85) begin
         return (pick & 1) ? btrc_pkg::ReqLength + 1'b1 : btrc_pkg::ReqLength - 1'b1;
      end
      return btrc_pkg::LengthWidth'($urandom);
   endfunction

   int idle_plan[4] = '{0, 86, 25, 0};

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed: smallest and largest values, zero, skipped nibbles, bad lengths.
      issue_request(btrc_pkg::ReqLength, 32'h0000_0001, 0);
      issue_request(btrc_pkg::ReqLength, 32'h9999_9999, 0);
      issue_request(btrc_pkg::ReqLength, 32'h9999_9998, 0);
      issue_request(btrc_pkg::ReqLength, 32'h1234_5678, 0);
      issue_request(btrc_pkg::ReqLength, 32'h1000_0000, 0);
      issue_request(btrc_pkg::ReqLength, 32'h0000_0000, 0);
      issue_request(btrc_pkg::ReqLength, 32'hFFFF_FFFF, 0);
      issue_request(btrc_pkg::ReqLength, 32'hAAAA_AAAA, 0);
      issue_request(btrc_pkg::ReqLength, 32'h0000_000A, 0);
      issue_request(btrc_pkg::ReqLength, 32'hA1B2_C3D4, 0);
      issue_request(btrc_pkg::ReqLength, 32'hA000_0001, 0);
      issue_request(btrc_pkg::ReqLength, 32'hF9F9_F9F9, 0);
      issue_request(btrc_pkg::ReqLength, 32'h9AAA_AAAA, 0);
      issue_request(btrc_pkg::ReqLength, 32'hE0F0_D0C1, 0);
      issue_request(8'd0,      32'h9999_9999, 0);
      issue_request(8'd255,    32'h0000_0001, 0);
      issue_request(8'd4,      32'h1234_5678, 0);
      issue_request(8'd6,      32'h1234_5678, 0);
      issue_request(8'd133,    32'h5555_5555, 0);
      issue_request(8'd250,    32'hFFFF_FFFF, 0);

      // Random requests over several sender gap profiles.
      foreach (idle_plan[p]) begin
         repeat (PhaseItems) begin
            issue_request(random_pdu_length(), random_bcd_word(), idle_plan[p]);
         end
      end
      start <= 1'b0;

      // Drain the pipeline, then give stray replies a chance to show.
      while (board.pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      if (board.fails == 0 && board.pending_replies.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- bcd_timeout_request_check_core.f -----
+incdir+src
src/btrc_pkg.sv
src/btrc_digit_stage.sv
src/bcd_timeout_request_check_core.sv
tb/sv/tb_top.sv
